// ===== rtl/rgb2hls_pkg.sv =====
package rgb2hls_pkg;

   // field widths
   localparam int LEVEL_W = 10;
   localparam int HUE_W   = 9;
   localparam int PCT_W   = 7;

   // internal widths
   localparam int SUM_W   = LEVEL_W + 1;        // min + max, up to 2000
   localparam int DEN_W   = SUM_W;              // divisor width for both dividers
   localparam int REM_W   = 17;                 // spread * 100 fits in 17 bits
   localparam int QUO_W   = 7;                  // both quotients stay below 128
   localparam int DIV_STEPS = QUO_W;            // one quotient bit per stage

   // pipeline: input stage, operand stage, divider stages, output stage
   localparam int STAGES = DIV_STEPS + 3;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 10'd1000;
   localparam logic [SUM_W-1:0]   SUM_FULL    = 11'd2000;
   localparam logic [PCT_W-1:0]   LIGHT_HALF  = 7'd50;
   localparam logic [7:0]         LIGHT_RECIP = 8'd205;   // 205/1024 ~ 1/5
   localparam logic [PCT_W-1:0]   PCT_SCALE   = 7'd100;
   localparam logic [5:0]         HUE_SCALE   = 6'd60;
   localparam logic [HUE_W-1:0]   HUE_RED     = 9'd120;
   localparam logic [HUE_W-1:0]   HUE_GREEN   = 9'd240;
   localparam logic [HUE_W-1:0]   HUE_FULL    = 9'd360;

   // which component is largest
   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;

   typedef struct packed {
      logic [REM_W-1:0] sat_rem;
      logic [QUO_W-1:0] sat_quo;
      logic [DEN_W-1:0] sat_den;
      logic [REM_W-1:0] hue_rem;
      logic [QUO_W-1:0] hue_quo;
      logic [DEN_W-1:0] hue_den;
      logic [PCT_W-1:0] light;
      logic             neg;
      logic [1:0]       sel;
      logic             gray;
   } div_type;

   // one restoring step for both dividers; sh is the weight of the bit made here
   function automatic div_type div_step(input div_type s, input int unsigned sh);
      div_type          r;
      logic [REM_W-1:0] ts;
      logic [REM_W-1:0] th;
      r  = s;
      ts = REM_W'(s.sat_den) << sh;
      th = REM_W'(s.hue_den) << sh;
      r.sat_quo = {s.sat_quo[QUO_W-2:0], (s.sat_rem >= ts)};
      r.hue_quo = {s.hue_quo[QUO_W-2:0], (s.hue_rem >= th)};
      if (s.sat_rem >= ts) begin
         r.sat_rem = s.sat_rem - ts;
      end
      if (s.hue_rem >= th) begin
         r.hue_rem = s.hue_rem - th;
      end
      return r;
   endfunction

endpackage

// ===== rtl/rgb2hls_req_if.sv =====
interface rgb2hls_req_if import rgb2hls_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] red_level;
   logic [LEVEL_W-1:0] green_level;
   logic [LEVEL_W-1:0] blue_level;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, output ready);
endinterface

// ===== rtl/rgb2hls_rsp_if.sv =====
interface rgb2hls_rsp_if import rgb2hls_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [HUE_W-1:0] hue_degrees;
   logic [PCT_W-1:0] lightness_pct;
   logic [PCT_W-1:0] saturation_pct;

   modport source (output valid, output hue_degrees, output lightness_pct,
                   output saturation_pct, input ready);
   modport sink   (input valid, input hue_degrees, input lightness_pct,
                   input saturation_pct, output ready);
endinterface

// ===== rtl/rgb_to_hls_converter.sv =====
// RGB to HLS color converter.
// req_chan carries one color per request: red, green and blue levels on a
// 0..1000 scale (values above 1000 are clamped). rsp_chan returns hue in
// degrees (0..359, blue at 0, red at 120), lightness and saturation (0..100).
// Both channels use valid/ready; a request moves when both are high.
// One request per clock while rsp_chan is not stalled. The two divisions
// (saturation and hue) share a 7-stage restoring divider pipeline, one
// quotient bit a stage, between the operand stage and the output stage.
// Every stage has its own valid bit and advances when it is empty or the
// stage after it advances, so a stalled rsp_chan fills bubbles first and
// req_chan.ready drops only once every stage holds a request. Nothing is
// dropped or repeated across a stall.
// Reset (synchronous, active high) empties the pipeline; the block keeps
// no other state.
module rgb_to_hls_converter import rgb2hls_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rgb2hls_req_if.sink   req_chan,
   rgb2hls_rsp_if.source rsp_chan
);

   localparam int OUT = STAGES - 1;

   // stage valids and advance enables
   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   adv;

   always_comb begin
      adv[STAGES] = rsp_chan.ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_chan.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage A: clamp, min/max, winner and the signed hue difference
   // ---------------------------------------------------------------
   logic [LEVEL_W-1:0] red_c, green_c, blue_c;
   logic [LEVEL_W-1:0] lo, hi, dx, dy;
   logic [LEVEL_W:0]   diff;
   logic [1:0]         sel_in;

   logic [SUM_W-1:0]   a_sum_ff,    a_sum_in;
   logic [LEVEL_W-1:0] a_spread_ff, a_spread_in;
   logic [LEVEL_W-1:0] a_mag_ff,    a_mag_in;
   logic               a_neg_ff,    a_neg_in;
   logic [1:0]         a_sel_ff;
   logic               a_gray_ff,   a_gray_in;

   always_comb begin
      red_c   = (req_chan.red_level   > LEVEL_MAX) ? LEVEL_MAX : req_chan.red_level;
      green_c = (req_chan.green_level > LEVEL_MAX) ? LEVEL_MAX : req_chan.green_level;
      blue_c  = (req_chan.blue_level  > LEVEL_MAX) ? LEVEL_MAX : req_chan.blue_level;

      lo = (green_c < red_c) ? green_c : red_c;
      if (lo > blue_c) begin
         lo = blue_c;
      end
      hi = (green_c > red_c) ? green_c : red_c;
      if (hi < blue_c) begin
         hi = blue_c;
      end

      // ties: red beats green, green beats blue
      if (red_c == hi) begin
         sel_in = SEL_RED;
         dx     = green_c;
         dy     = blue_c;
      end else if (green_c == hi) begin
         sel_in = SEL_GREEN;
         dx     = blue_c;
         dy     = red_c;
      end else begin
         sel_in = SEL_BLUE;
         dx     = red_c;
         dy     = green_c;
      end

      diff        = {1'b0, dx} - {1'b0, dy};
      a_neg_in    = diff[LEVEL_W];
      a_mag_in    = a_neg_in ? LEVEL_W'(dy - dx) : diff[LEVEL_W-1:0];
      a_sum_in    = {1'b0, lo} + {1'b0, hi};
      a_spread_in = hi - lo;
      a_gray_in   = (lo == hi);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_sum_ff    <= a_sum_in;
         a_spread_ff <= a_spread_in;
         a_mag_ff    <= a_mag_in;
         a_neg_ff    <= a_neg_in;
         a_sel_ff    <= sel_in;
         a_gray_ff   <= a_gray_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage B: lightness, dividends and divisors
   // ---------------------------------------------------------------
   // sum / 20 == (sum >> 2) / 5, and (x * 205) >> 10 is exact for x <= 500
   logic [REM_W-1:0] light_prod;
   div_type          b_ff, b_in;

   always_comb begin
      light_prod   = REM_W'(a_sum_ff[SUM_W-1:2]) * REM_W'(LIGHT_RECIP);
      b_in         = '0;
      b_in.light   = light_prod[REM_W-1:10];
      b_in.sat_rem = REM_W'(a_spread_ff) * REM_W'(PCT_SCALE);
      b_in.hue_rem = REM_W'(a_mag_ff) * REM_W'(HUE_SCALE);
      // dark half divides by the sum, light half by what is left to 2000
      b_in.sat_den = (b_in.light < LIGHT_HALF) ? a_sum_ff : SUM_FULL - a_sum_ff;
      b_in.hue_den = DEN_W'(a_spread_ff);
      b_in.neg     = a_neg_ff;
      b_in.sel     = a_sel_ff;
      b_in.gray    = a_gray_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         b_ff <= b_in;
      end
   end

   // ---------------------------------------------------------------
   // Divider stages: MSB of the quotient first, one bit per stage.
   // Grays give a zero hue divisor here; their results are forced at the output.
   // ---------------------------------------------------------------
   div_type d_src [DIV_STEPS];
   div_type d_in  [DIV_STEPS];
   div_type d_ff  [DIV_STEPS];

   always_comb begin
      d_src[0] = b_ff;
      for (int j = 1; j < DIV_STEPS; j++) begin
         d_src[j] = d_ff[j-1];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
         d_in[j] = div_step(d_src[j], DIV_STEPS - 1 - j);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (adv[j+2]) begin
            d_ff[j] <= d_in[j];
         end
      end
   end

   // ---------------------------------------------------------------
   // Output stage: hue offset and wrap, gray override
   // ---------------------------------------------------------------
   div_type          fin;
   logic [HUE_W-1:0] mag9;
   logic [HUE_W-1:0] hue_in;
   logic [PCT_W-1:0] sat_in;

   logic [HUE_W-1:0] o_hue_ff;
   logic [PCT_W-1:0] o_light_ff;
   logic [PCT_W-1:0] o_sat_ff;

   always_comb begin
      fin  = d_ff[DIV_STEPS-1];
      mag9 = HUE_W'(fin.hue_quo);
      unique case (fin.sel)
         SEL_RED:   hue_in = fin.neg ? HUE_RED - mag9 : HUE_RED + mag9;
         SEL_GREEN: hue_in = fin.neg ? HUE_GREEN - mag9 : HUE_GREEN + mag9;
         SEL_BLUE:  begin
            // 360 + q wraps to q when q >= 0
            hue_in = (fin.neg && mag9 != '0) ? HUE_FULL - mag9 : mag9;
         end
         default:   hue_in = '0;
      endcase
      sat_in = fin.sat_quo;
      if (fin.gray) begin
         hue_in = '0;
         sat_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[OUT]) begin
         o_hue_ff   <= hue_in;
         o_light_ff <= fin.light;
         o_sat_ff   <= sat_in;
      end
   end

   assign rsp_chan.valid          = valid_ff[OUT];
   assign rsp_chan.hue_degrees    = o_hue_ff;
   assign rsp_chan.lightness_pct  = o_light_ff;
   assign rsp_chan.saturation_pct = o_sat_ff;

endmodule
